### sv/ebrm_pkg.sv
// Shared types, codes and helpers for the eight-bit register machine step unit.
// Used by the controller, the datapath, the top level and the checker.
package ebrm_pkg;

    // Machine sizes
    localparam int DATA_DEPTH     = 256;
    localparam int REGISTER_COUNT = 8;
    localparam int DATA_W         = 8;
    localparam int ADDR_W         = $clog2(DATA_DEPTH);
    localparam int REG_IDX_W      = $clog2(REGISTER_COUNT);
    localparam int DIV_CNT_W      = $clog2(DATA_W);
    localparam int SRC_W          = 4;
    localparam int OP_W           = 4;

    // Operand source codes beyond the register file
    localparam logic [SRC_W-1:0] SRC_PC  = SRC_W'(8);
    localparam logic [SRC_W-1:0] SRC_IMM = SRC_W'(9);

    typedef enum logic [OP_W-1:0] {
        OP_MOV     = 4'd0,
        OP_INC     = 4'd1,
        OP_DEC     = 4'd2,
        OP_ADD     = 4'd3,
        OP_SUB     = 4'd4,
        OP_MUL     = 4'd5,
        OP_DIV     = 4'd6,
        OP_AND     = 4'd7,
        OP_OR      = 4'd8,
        OP_XOR     = 4'd9,
        OP_JLT     = 4'd10,
        OP_JEQ     = 4'd11,
        OP_JGT     = 4'd12,
        OP_INT     = 4'd13,
        OP_HLT     = 4'd14,
        OP_INVALID = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HALT    = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_DIV,
        S_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic fetch;
        logic exec;
        logic div_step;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

    // Fold an 8-bit value into the data memory range by conditional subtraction
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [DATA_W-1:0] v);
        logic [11:0] t;
        t = {4'b0, v};
        for (int k = 3; k >= 0; k--) begin
            if (t >= (12'(DATA_DEPTH) << k)) begin
                t = t - (12'(DATA_DEPTH) << k);
            end
        end
        return t[ADDR_W-1:0];
    endfunction

endpackage

### sv/ebrm_ctrl.sv
// Sequencing controller for the register machine step unit.
// Depends on ebrm_pkg; drives commands into ebrm_dpath and owns both handshakes.
module ebrm_ctrl import ebrm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_out_vld  = r_out_vld & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_div ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // Hold until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;

endmodule

### sv/ebrm_dpath.sv
// Datapath of the register machine step unit: register file, data memory,
// program counter, ALU, bit-serial divider and output register. Depends on ebrm_pkg.
module ebrm_dpath import ebrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [SRC_W-1:0]  i_first_source,
    input  logic              i_first_indirect,
    input  logic [DATA_W-1:0] i_first_value,
    input  logic [SRC_W-1:0]  i_second_source,
    input  logic              i_second_indirect,
    input  logic [DATA_W-1:0] i_second_value,
    input  logic [SRC_W-1:0]  i_third_source,
    input  logic              i_third_indirect,
    input  logic [DATA_W-1:0] i_third_value,
    output logic [DATA_W-1:0] o_next_pc,
    output logic [1:0]        o_status
);

    // Instruction register
    t_op               r_op;
    logic [SRC_W-1:0]  r_s1, r_s2, r_s3;
    logic              r_i1, r_i2, r_i3;
    logic [DATA_W-1:0] r_v1, r_v2, r_v3;

    // Architectural state
    logic [DATA_W-1:0]     r_gpr [REGISTER_COUNT];
    logic [DATA_W-1:0]     r_pc;
    logic [DATA_W-1:0]     r_mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] r_mem_vld;

    // Operand fetch registers
    logic [DATA_W-1:0] r_dir_a, r_dir_b, r_rd_a, r_rd_b;
    logic              r_vld_a, r_vld_b;
    logic [ADDR_W-1:0] r_addr_a;

    // Execute results
    logic [DATA_W-1:0] r_res, n_res;
    logic [DATA_W-1:0] r_next, n_next;
    t_status           r_stat, n_stat;
    logic              r_wr_en, n_wr_en;

    // Divider
    logic [DATA_W-1:0]    r_div_rem, r_div_quo, r_div_den;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DATA_W:0]      div_shift;
    logic [DATA_W:0]      div_diff;
    logic [DATA_W-1:0]    div_rem_nx, div_quo_nx;

    // Output register
    logic [DATA_W-1:0] r_out_pc;
    t_status           r_out_stat;

    logic              is_jump;
    logic [SRC_W-1:0]  src_a;
    logic              ind_a;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] dir_a, dir_b;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [DATA_W-1:0] opnd_a, opnd_b;
    logic [2*DATA_W-1:0] product;
    logic [DATA_W-1:0] pc_inc;
    logic              dest_ok;
    logic              take;

    // Operand A is the first operand, or the third for compare-jumps
    assign is_jump = (r_op == OP_JLT) || (r_op == OP_JEQ) || (r_op == OP_JGT);
    assign src_a   = is_jump ? r_s3 : r_s1;
    assign ind_a   = is_jump ? r_i3 : r_i1;
    assign val_a   = is_jump ? r_v3 : r_v1;

    // Direct operand values
    always_comb begin
        if (src_a < SRC_W'(REGISTER_COUNT)) begin
            dir_a = r_gpr[src_a[REG_IDX_W-1:0]];
        end else if (src_a == SRC_PC) begin
            dir_a = r_pc;
        end else begin
            dir_a = val_a;
        end
        if (r_s2 < SRC_W'(REGISTER_COUNT)) begin
            dir_b = r_gpr[r_s2[REG_IDX_W-1:0]];
        end else if (r_s2 == SRC_PC) begin
            dir_b = r_pc;
        end else begin
            dir_b = r_v2;
        end
    end

    assign addr_a = wrap_addr(dir_a);
    assign addr_b = wrap_addr(dir_b);

    // Latch the instruction beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_operation);
            r_s1 <= i_first_source;
            r_i1 <= i_first_indirect;
            r_v1 <= i_first_value;
            r_s2 <= i_second_source;
            r_i2 <= i_second_indirect;
            r_v2 <= i_second_value;
            r_s3 <= i_third_source;
            r_i3 <= i_third_indirect;
            r_v3 <= i_third_value;
        end
    end

    // Fetch: register direct values and read both memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_dir_a  <= dir_a;
            r_dir_b  <= dir_b;
            r_addr_a <= addr_a;
            r_rd_a   <= r_mem[addr_a];
            r_rd_b   <= r_mem[addr_b];
        end
    end

    // Never-written memory entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_cmd.fetch) begin
            r_vld_a <= r_mem_vld[addr_a];
            r_vld_b <= r_mem_vld[addr_b];
        end
    end

    assign opnd_a = ind_a ? (r_vld_a ? r_rd_a : '0) : r_dir_a;
    assign opnd_b = r_i2  ? (r_vld_b ? r_rd_b : '0) : r_dir_b;

    // Execute: ALU, compare, status and next PC
    assign product = opnd_a * opnd_b;
    assign pc_inc  = r_pc + DATA_W'(1);
    assign dest_ok = r_i1 || (r_s1 < SRC_W'(REGISTER_COUNT));

    always_comb begin
        n_res   = '0;
        n_next  = pc_inc;
        n_stat  = ST_OK;
        n_wr_en = 1'b0;
        take    = 1'b0;
        case (r_op)
            OP_MOV: n_res = opnd_b;
            OP_INC: n_res = opnd_a + DATA_W'(1);
            OP_DEC: n_res = opnd_a - DATA_W'(1);
            OP_ADD: n_res = opnd_a + opnd_b;
            OP_SUB: n_res = opnd_a - opnd_b;
            OP_MUL: n_res = product[DATA_W-1:0];
            OP_AND: n_res = opnd_a & opnd_b;
            OP_OR:  n_res = opnd_a | opnd_b;
            OP_XOR: n_res = opnd_a ^ opnd_b;
            OP_JLT: take  = opnd_b < opnd_a;
            OP_JEQ: take  = opnd_b == opnd_a;
            OP_JGT: take  = opnd_b > opnd_a;
            default: n_res = '0;
        endcase
        if (r_op <= OP_XOR) begin
            if (r_op == OP_DIV && opnd_b == '0) begin
                n_stat = ST_DIVZERO;
                n_next = r_pc;
            end else if (!dest_ok) begin
                n_stat = ST_IGNORED;
            end else begin
                n_wr_en = 1'b1;
            end
        end else if (is_jump) begin
            if (take) begin
                n_next = r_v1;
            end
        end else if (r_op == OP_HLT) begin
            n_stat = ST_HALT;
            n_next = r_pc;
        end else if (r_op == OP_INVALID) begin
            n_stat = ST_IGNORED;
        end
    end

    assign o_sts.need_div = (r_op == OP_DIV) && (opnd_b != '0) && dest_ok;
    assign o_sts.div_last = (r_div_cnt == DIV_CNT_W'(DATA_W - 1));

    // One restoring divide step per cycle
    assign div_shift  = {r_div_rem, r_div_quo[DATA_W-1]};
    assign div_diff   = div_shift - {1'b0, r_div_den};
    assign div_rem_nx = div_diff[DATA_W] ? div_shift[DATA_W-1:0] : div_diff[DATA_W-1:0];
    assign div_quo_nx = {r_div_quo[DATA_W-2:0], ~div_diff[DATA_W]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res     <= n_res;
            r_next    <= n_next;
            r_stat    <= n_stat;
            r_wr_en   <= n_wr_en;
            r_div_rem <= '0;
            r_div_quo <= opnd_a;
            r_div_den <= opnd_b;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_rem_nx;
            r_div_quo <= div_quo_nx;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            r_res     <= div_quo_nx;
        end
    end

    // Commit: register file, program counter and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REGISTER_COUNT; k++) begin
                r_gpr[k] <= '0;
            end
            r_pc      <= '0;
            r_mem_vld <= '0;
        end else if (i_cmd.commit) begin
            r_pc <= r_next;
            if (r_wr_en) begin
                if (r_i1) begin
                    r_mem_vld[r_addr_a] <= 1'b1;
                end else begin
                    r_gpr[r_s1[REG_IDX_W-1:0]] <= r_res;
                end
            end
        end
    end

    // Commit: data memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_wr_en && r_i1) begin
            r_mem[r_addr_a] <= r_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_pc   <= r_next;
            r_out_stat <= r_stat;
        end
    end

    assign o_next_pc = r_out_pc;
    assign o_status  = r_out_stat;

endmodule

### sv/eight_bit_register_machine_step_unit.sv
// Top level of the eight-bit register machine step unit.
// Depends on ebrm_pkg, ebrm_ctrl and ebrm_dpath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | operation, three operand triples
//  out     | output    | o_out_valid / i_out_ready | next_pc, status
//
// An instruction holds the unit through accept, fetch, execute and commit; its result is
// registered into the output register at commit. DIV with a nonzero divisor and a writable
// destination also passes through the divide state of the one-bit-per-cycle divider.
// The next beat is accepted the cycle after commit, even while the result still waits.
// Reset clears the registers, the program counter and the memory valid bits at once.
// A stalled output holds the unit in commit until the output register is taken.
module eight_bit_register_machine_step_unit import ebrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [SRC_W-1:0]  i_first_source,
    input  logic              i_first_indirect,
    input  logic [DATA_W-1:0] i_first_value,
    input  logic [SRC_W-1:0]  i_second_source,
    input  logic              i_second_indirect,
    input  logic [DATA_W-1:0] i_second_value,
    input  logic [SRC_W-1:0]  i_third_source,
    input  logic              i_third_indirect,
    input  logic [DATA_W-1:0] i_third_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_next_pc,
    output logic [1:0]        o_status
);

    t_cmd cmd;
    t_sts sts;

    ebrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ebrm_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (i_operation),
        .i_first_source    (i_first_source),
        .i_first_indirect  (i_first_indirect),
        .i_first_value     (i_first_value),
        .i_second_source   (i_second_source),
        .i_second_indirect (i_second_indirect),
        .i_second_value    (i_second_value),
        .i_third_source    (i_third_source),
        .i_third_indirect  (i_third_indirect),
        .i_third_value     (i_third_value),
        .o_next_pc         (o_next_pc),
        .o_status          (o_status)
    );

endmodule

### sv/ebrm_checker.sv
// Port-level checks for the eight-bit register machine step unit.
// Depends on ebrm_pkg; bound to the top level at the end of this file.
module ebrm_checker import ebrm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] o_next_pc,
    input logic [1:0]        o_status
);

    // A waiting result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_next_pc) && $stable(o_status))
        else $error("output beat changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Only one instruction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat accepted while busy");

    // Output valid does not rise while the accepted instruction is in fetch or execute
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##1 !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result produced too early");

endmodule

bind eight_bit_register_machine_step_unit ebrm_checker u_ebrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_next_pc   (o_next_pc),
    .o_status    (o_status)
);

### tb/testbench.sv
// Self-checking bench for eight_bit_register_machine_step_unit: directed and random
// instructions, checked against a cycle-free predictor of registers, memory and PC.
// Depends on ebrm_pkg and the step unit RTL.
import ebrm_pkg::*;

typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic              ind;
    logic [DATA_W-1:0] val;
} operand_t;

typedef struct packed {
    t_op      op;
    operand_t first;
    operand_t second;
    operand_t third;
} instr_t;

typedef struct packed {
    logic [DATA_W-1:0] next_pc;
    t_status           status;
} step_result_t;

// Machine state predictor plus the queue of results still owed by the unit
class ebrm_scoreboard;
    logic [DATA_W-1:0] regs[REGISTER_COUNT];
    logic [DATA_W-1:0] mem[DATA_DEPTH];
    logic [DATA_W-1:0] pc;
    step_result_t      owed[$];
    int                n_errors;
    int                n_checked;
    int                n_jumps;
    int                n_by_status[4];

    function new();
        foreach (regs[k]) regs[k] = '0;
        foreach (mem[k]) mem[k] = '0;
        pc = '0;
        n_errors = 0;
        n_checked = 0;
        n_jumps = 0;
        foreach (n_by_status[k]) n_by_status[k] = 0;
    endfunction

    function logic [DATA_W-1:0] direct_value(operand_t o);
        if (o.src < REGISTER_COUNT) return regs[o.src[REG_IDX_W-1:0]];
        if (o.src == SRC_PC) return pc;
        return o.val;
    endfunction

    function logic [DATA_W-1:0] read_operand(operand_t o);
        logic [DATA_W-1:0] v;
        v = direct_value(o);
        if (o.ind) return mem[int'(v) % DATA_DEPTH];
        return v;
    endfunction

    // Execute one accepted instruction on the predicted state and queue its result
    function void note_instruction(instr_t it);
        step_result_t      res;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] r;
        res.next_pc = pc + 8'd1;
        res.status  = ST_OK;
        case (it.op)
            OP_INT: ;
            OP_HLT: begin
                res.status  = ST_HALT;
                res.next_pc = pc;
            end
            OP_INVALID: res.status = ST_IGNORED;
            OP_JLT, OP_JEQ, OP_JGT: begin
                x = read_operand(it.second);
                y = read_operand(it.third);
                if ((it.op == OP_JLT && x < y) || (it.op == OP_JEQ && x == y) ||
                    (it.op == OP_JGT && x > y)) begin
                    res.next_pc = it.first.val;
                    n_jumps++;
                end
            end
            default: begin
                y = read_operand(it.second);
                if (it.op == OP_DIV && y == '0) begin
                    res.status  = ST_DIVZERO;
                    res.next_pc = pc;
                end else if (!it.first.ind && it.first.src >= REGISTER_COUNT) begin
                    res.status = ST_IGNORED;
                end else begin
                    x = read_operand(it.first);
                    case (it.op)
                        OP_MOV: r = y;
                        OP_INC: r = x + 8'd1;
                        OP_DEC: r = x - 8'd1;
                        OP_ADD: r = x + y;
                        OP_SUB: r = x - y;
                        OP_MUL: r = x * y;
                        OP_DIV: r = x / y;
                        OP_AND: r = x & y;
                        OP_OR:  r = x | y;
                        default: r = x ^ y;
                    endcase
                    if (it.first.ind) begin
                        mem[int'(direct_value(it.first)) % DATA_DEPTH] = r;
                    end else begin
                        regs[it.first.src[REG_IDX_W-1:0]] = r;
                    end
                end
            end
        endcase
        pc = res.next_pc;
        owed.push_back(res);
    endfunction

    // Compare one output beat with the oldest owed result
    function void check_result(logic [DATA_W-1:0] next_pc, t_status status);
        step_result_t exp;
        if (owed.size() == 0) begin
            $error("output beat with no instruction pending: next_pc %0d status %0d",
                   next_pc, status);
            n_errors++;
            return;
        end
        exp = owed.pop_front();
        n_checked++;
        n_by_status[exp.status]++;
        if (next_pc !== exp.next_pc) begin
            $error("next_pc mismatch: expected %0d, actual %0d", exp.next_pc, next_pc);
            n_errors++;
        end
        if (status !== exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp.status, status);
            n_errors++;
        end
    endfunction

    function int pending();
        return owed.size();
    endfunction
endclass

module testbench;
    localparam int RANDOM_ITEMS = 702;

    // Register operands and the upper source codes that read as immediates
    localparam logic [SRC_W-1:0] REG_A         = 4'd0;
    localparam logic [SRC_W-1:0] REG_B         = 4'd1;
    localparam logic [SRC_W-1:0] REG_C         = 4'd2;
    localparam logic [SRC_W-1:0] REG_D         = 4'd3;
    localparam logic [SRC_W-1:0] REG_H         = 4'd7;
    localparam logic [SRC_W-1:0] SRC_IMM_ALIAS = 4'd12;
    localparam logic [SRC_W-1:0] SRC_IMM_TOP   = 4'd15;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_operation = '0;
    logic [SRC_W-1:0]  i_first_source = '0;
    logic              i_first_indirect = 1'b0;
    logic [DATA_W-1:0] i_first_value = '0;
    logic [SRC_W-1:0]  i_second_source = '0;
    logic              i_second_indirect = 1'b0;
    logic [DATA_W-1:0] i_second_value = '0;
    logic [SRC_W-1:0]  i_third_source = '0;
    logic              i_third_indirect = 1'b0;
    logic [DATA_W-1:0] i_third_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_next_pc;
    logic [1:0]        o_status;

    int             send_idle_pct = 28;
    int             recv_idle_pct = 65;
    ebrm_scoreboard sb;

    eight_bit_register_machine_step_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_first_source    (i_first_source),
        .i_first_indirect  (i_first_indirect),
        .i_first_value     (i_first_value),
        .i_second_source   (i_second_source),
        .i_second_indirect (i_second_indirect),
        .i_second_value    (i_second_value),
        .i_third_source    (i_third_source),
        .i_third_indirect  (i_third_indirect),
        .i_third_value     (i_third_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_next_pc         (o_next_pc),
        .o_status          (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic operand_t opnd(logic [SRC_W-1:0] src, logic ind, logic [DATA_W-1:0] val);
        operand_t o;
        o.src = src;
        o.ind = ind;
        o.val = val;
        return o;
    endfunction

    function automatic instr_t mk(t_op op, operand_t a, operand_t b, operand_t c);
        instr_t it;
        it.op     = op;
        it.first  = a;
        it.second = b;
        it.third  = c;
        return it;
    endfunction

    // Mostly registers, with PC, immediates and the aliased upper codes mixed in
    function automatic operand_t random_operand();
        operand_t o;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) o.src = SRC_W'($urandom_range(0, REGISTER_COUNT - 1));
        else if (pick < 80) o.src = SRC_IMM;
        else if (pick < 90) o.src = SRC_PC;
        else o.src = SRC_W'($urandom_range(SRC_IMM + 1, SRC_IMM_TOP));
        o.ind = ($urandom_range(0, 99) < 30);
        o.val = DATA_W'($urandom_range(0, 255));
        return o;
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) it.op = t_op'($urandom_range(OP_MOV, OP_XOR));
        else if (pick < 90) it.op = t_op'($urandom_range(OP_JLT, OP_JGT));
        else it.op = t_op'($urandom_range(OP_INT, OP_INVALID));
        it.first  = random_operand();
        it.second = random_operand();
        it.third  = random_operand();
        return it;
    endfunction

    // Hold valid low for a random gap, then present the beat until it is taken
    task automatic send_instr(input instr_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= it.op;
        i_first_source    <= it.first.src;
        i_first_indirect  <= it.first.ind;
        i_first_value     <= it.first.val;
        i_second_source   <= it.second.src;
        i_second_indirect <= it.second.ind;
        i_second_value    <= it.second.val;
        i_third_source    <= it.third.src;
        i_third_indirect  <= it.third.ind;
        i_third_value     <= it.third.val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_instruction(it);
    endtask

    // Check output beats and randomly stall the result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_next_pc, t_status'(o_status));
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        operand_t none;
        sb = new();
        none = opnd(SRC_IMM, 1'b0, 8'd0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: wraparound, every operation, memory access, refused writes, halts
        send_instr(mk(OP_MOV, opnd(REG_A, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd255), none));
        send_instr(mk(OP_INC, opnd(REG_A, 1'b0, 8'd0), none, none));
        send_instr(mk(OP_DEC, opnd(REG_A, 1'b0, 8'd0), none, none));
        send_instr(mk(OP_MOV, opnd(REG_B, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd16), none));
        send_instr(mk(OP_ADD, opnd(REG_A, 1'b0, 8'd0), opnd(REG_B, 1'b0, 8'd0), none));
        send_instr(mk(OP_SUB, opnd(REG_B, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd32), none));
        send_instr(mk(OP_MUL, opnd(REG_B, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd255), none));
        send_instr(mk(OP_DIV, opnd(REG_A, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd0), none));
        send_instr(mk(OP_DIV, opnd(REG_A, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd7), none));
        send_instr(mk(OP_MOV, opnd(SRC_IMM, 1'b1, 8'd200), opnd(SRC_IMM, 1'b0, 8'hA5), none));
        send_instr(mk(OP_AND, opnd(SRC_IMM, 1'b1, 8'd200), opnd(REG_B, 1'b0, 8'd0), none));
        send_instr(mk(OP_OR, opnd(REG_C, 1'b0, 8'd0), opnd(SRC_IMM, 1'b1, 8'd200), none));
        send_instr(mk(OP_XOR, opnd(REG_B, 1'b1, 8'd0), opnd(SRC_IMM, 1'b0, 8'hFF), none));
        send_instr(mk(OP_DIV, opnd(REG_C, 1'b0, 8'd0), opnd(SRC_IMM, 1'b1, 8'd200), none));
        send_instr(mk(OP_MOV, opnd(SRC_PC, 1'b0, 8'd0), opnd(SRC_IMM, 1'b0, 8'd9), none));
        send_instr(mk(OP_MOV, opnd(SRC_IMM, 1'b0, 8'd5), opnd(SRC_IMM, 1'b0, 8'd9), none));
        send_instr(mk(OP_INC, opnd(SRC_IMM_TOP, 1'b0, 8'd1), none, none));
        send_instr(mk(OP_MOV, opnd(REG_D, 1'b0, 8'd0), opnd(SRC_IMM_ALIAS, 1'b0, 8'h3C), none));
        send_instr(mk(OP_MOV, opnd(REG_H, 1'b0, 8'd0), opnd(SRC_PC, 1'b0, 8'd0), none));
        send_instr(mk(OP_JLT, opnd(REG_A, 1'b1, 8'd40), opnd(REG_A, 1'b0, 8'd0),
                      opnd(SRC_IMM, 1'b0, 8'd255)));
        send_instr(mk(OP_JEQ, opnd(SRC_IMM, 1'b0, 8'd255), opnd(SRC_IMM, 1'b1, 8'd200),
                      opnd(SRC_IMM, 1'b1, 8'd200)));
        send_instr(mk(OP_JGT, opnd(REG_C, 1'b0, 8'd0), opnd(REG_A, 1'b0, 8'd0),
                      opnd(SRC_IMM, 1'b0, 8'd255)));
        send_instr(mk(OP_JGT, opnd(SRC_PC, 1'b0, 8'd77), opnd(SRC_PC, 1'b0, 8'd0),
                      opnd(SRC_IMM_TOP, 1'b0, 8'd0)));
        send_instr(mk(OP_INT, none, none, none));
        send_instr(mk(OP_HLT, none, none, none));
        send_instr(mk(OP_INVALID, opnd(REG_A, 1'b0, 8'd0), none, none));

        // Random: receiver-heavy idling, then sender-heavy, then back to back
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 28 : 0;
            repeat (RANDOM_ITEMS / 3) send_instr(random_instr());
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then allow the unit to settle
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("summary: %0d results checked, %0d jumps taken", sb.n_checked, sb.n_jumps);
        $display("summary: status ok %0d, halt %0d, divide by zero %0d, ignored %0d",
                 sb.n_by_status[ST_OK], sb.n_by_status[ST_HALT],
                 sb.n_by_status[ST_DIVZERO], sb.n_by_status[ST_IGNORED]);
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: generous bound for a run of divides under heavy stalls
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end
endmodule
